@@ src/apc_pkg.sv @@
// Shared types for the amicable pair checker.
package apc_pkg;

   // Status returned by the remainder unit to the sequencer.
   typedef struct packed {
      logic done;      // one-cycle pulse: remainder is final
      logic zero_rem;  // remainder is zero, valid with done
   } div_status_type;

endpackage

@@ src/apc_rem_unit.sv @@
// Restoring remainder unit: one dividend bit per cycle, shared by every trial divisor.
module apc_rem_unit #(
   parameter int NUM_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_WIDTH-1:0]    dividend,
   input  logic [NUM_WIDTH-1:0]    divisor,
   output apc_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] dvd_ff, dvd_in;
   logic [NUM_WIDTH-1:0] dsr_ff, dsr_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH:0]   trial_rem;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      trial_rem = {rem_ff, dvd_ff[NUM_WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_WIDTH);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial_rem >= {1'b0, dsr_ff}) begin
            rem_in = NUM_WIDTH'(trial_rem - {1'b0, dsr_ff});
         end else begin
            rem_in = trial_rem[NUM_WIDTH-1:0];
         end
         dvd_in = {dvd_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.zero_rem = (rem_ff == '0);

endmodule

@@ src/amicable_pair_checker.sv @@
// Top level of the amicable pair checker: sequencer, divisor sums and result register.
//
// Usage: present two unsigned numbers on req_first_number / req_second_number with
// req_valid; the word is taken when req_valid and req_ready are both high. One result
// word follows on rsp_is_amicable with rsp_valid, held until rsp_ready is high.
// The flag is 1 when the proper divisor sum of each number equals the other.
// Each number n is tested against every trial divisor 1..n/2 by one shared restoring
// remainder unit; each trial passes through the start and wait states, and numbers
// below two skip the trials.
// One word is in work at a time: req_ready is high only while the sequencer is idle.
// A finished result sits in the output register, so a new word is taken while the
// receiver stalls; the next result waits for that register to drain.
// Reset (synchronous, active high) returns the sequencer to idle and drops any
// pending result.
module amicable_pair_checker #(
   parameter int NUM_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [NUM_WIDTH-1:0] req_first_number,
   input  logic [NUM_WIDTH-1:0] req_second_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_amicable
);

   localparam int SUM_W = NUM_WIDTH + 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 sel_ff, sel_in;
   logic [NUM_WIDTH-1:0] held_first_ff, held_first_in;
   logic [NUM_WIDTH-1:0] held_second_ff, held_second_in;
   logic [NUM_WIDTH-1:0] trial_divisor_ff, trial_divisor_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     sum_first_ff, sum_first_in;
   logic [SUM_W-1:0]     sum_second_ff, sum_second_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_flag_ff, rsp_flag_in;

   logic [NUM_WIDTH-1:0]    cur_num;
   logic [SUM_W-1:0]        acc_add;
   logic                    finish;
   logic [SUM_W-1:0]        finish_sum;
   logic                    div_start;
   apc_pkg::div_status_type div_status;

   apc_rem_unit #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur_num),
      .divisor  (trial_divisor_ff),
      .status   (div_status)
   );

   assign cur_num   = sel_ff ? held_second_ff : held_first_ff;
   assign div_start = (state_ff == ST_START);
   assign acc_add   = acc_ff + (div_status.zero_rem ?
                                SUM_W'(trial_divisor_ff) : SUM_W'(0));

   always_comb begin
      state_in         = state_ff;
      sel_in           = sel_ff;
      held_first_in    = held_first_ff;
      held_second_in   = held_second_ff;
      trial_divisor_in = trial_divisor_ff;
      acc_in           = acc_ff;
      sum_first_in     = sum_first_ff;
      sum_second_in    = sum_second_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_flag_in      = rsp_flag_ff;
      finish           = 1'b0;
      finish_sum       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               held_first_in  = req_first_number;
               held_second_in = req_second_number;
               sel_in         = 1'b0;
               state_in       = ST_SETUP;
            end
         end
         ST_SETUP: begin
            acc_in           = '0;
            trial_divisor_in = NUM_WIDTH'(1);
            // zero and one have no proper divisors
            if (cur_num < NUM_WIDTH'(2)) begin
               finish     = 1'b1;
               finish_sum = '0;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               acc_in = acc_add;
               if (trial_divisor_ff == (cur_num >> 1)) begin
                  finish     = 1'b1;
                  finish_sum = acc_add;
               end else begin
                  trial_divisor_in = trial_divisor_ff + NUM_WIDTH'(1);
                  state_in         = ST_START;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = (sum_first_ff == SUM_W'(held_second_ff)) &&
                              (sum_second_ff == SUM_W'(held_first_ff));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (!sel_ff) begin
            sum_first_in = finish_sum;
            sel_in       = 1'b1;
            state_in     = ST_SETUP;
         end else begin
            sum_second_in = finish_sum;
            state_in      = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_first_ff    <= held_first_in;
      held_second_ff   <= held_second_in;
      trial_divisor_ff <= trial_divisor_in;
      acc_ff           <= acc_in;
      sum_first_ff     <= sum_first_in;
      sum_second_ff    <= sum_second_in;
      rsp_flag_ff      <= rsp_flag_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_amicable = rsp_flag_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the amicable pair checker: directed and random number pairs.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_WIDTH = 16;

   typedef struct {
      logic [NUM_WIDTH-1:0] first_num;
      logic [NUM_WIDTH-1:0] second_num;
      logic                 flag;
   } pair_verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [NUM_WIDTH-1:0] req_first_number = '0;
   logic [NUM_WIDTH-1:0] req_second_number = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_is_amicable;

   pair_verdict_type verdicts_due[$];
   int               mismatch_count = 0;
   int               req_gap_pct = 0;
   int               rsp_stall_pct = 0;

   // Small amicable pairs and perfect numbers, cheap enough to run often.
   logic [NUM_WIDTH-1:0] known_first[5]  = '{16'd220, 16'd1184, 16'd6, 16'd28, 16'd496};
   logic [NUM_WIDTH-1:0] known_second[5] = '{16'd284, 16'd1210, 16'd6, 16'd28, 16'd496};

   amicable_pair_checker #(.NUM_WIDTH(NUM_WIDTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_number  (req_first_number),
      .req_second_number (req_second_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_amicable   (rsp_is_amicable)
   );

   always #10 clock = ~clock;

   // Sum of the divisors of n that are at most n/2; zero for 0 and 1.
   function automatic logic [NUM_WIDTH+2:0] proper_divisor_sum(input logic [NUM_WIDTH-1:0] n);
      longint unsigned total;
      longint unsigned d;
      total = 0;
      for (d = 1; d * d <= n; d++) begin
         if (n % d == 0) begin
            total += d;
            if (n / d != d) total += n / d;
         end
      end
      return (NUM_WIDTH+3)'(total - n);
   endfunction

   function automatic logic predict_amicable(input logic [NUM_WIDTH-1:0] a,
                                             input logic [NUM_WIDTH-1:0] b);
      return (proper_divisor_sum(a) == {3'b000, b}) && (proper_divisor_sum(b) == {3'b000, a});
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_pair(input logic [NUM_WIDTH-1:0] a, input logic [NUM_WIDTH-1:0] b);
      pair_verdict_type v;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_first_number  <= a;
      req_second_number <= b;
      do @(posedge clock); while (!req_ready);
      v.first_num  = a;
      v.second_num = b;
      v.flag       = predict_amicable(a, b);
      verdicts_due.push_back(v);
   endtask

   task automatic report_mismatch(input string what, input pair_verdict_type v, input logic got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s first=%0d second=%0d expected=%0b actual=%0b",
                  what, v.first_num, v.second_num, v.flag, got);
   endtask

   always @(posedge clock) begin
      pair_verdict_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            v.first_num  = '0;
            v.second_num = '0;
            v.flag       = 1'bx;
            report_mismatch("unexpected word", v, rsp_is_amicable);
         end else begin
            v = verdicts_due.pop_front();
            if (rsp_is_amicable !== v.flag) report_mismatch("is_amicable", v, rsp_is_amicable);
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic test_zero_and_one();
      send_pair(16'd0, 16'd0);
      send_pair(16'd0, 16'd1);
      send_pair(16'd1, 16'd0);
      send_pair(16'd1, 16'd1);
      send_pair(16'd2, 16'd1);
      send_pair(16'd0, 16'd2);
   endtask

   task automatic test_self_pairs();
      send_pair(16'd6, 16'd6);
      send_pair(16'd28, 16'd28);
      send_pair(16'd496, 16'd496);
      send_pair(16'd12, 16'd12);
      send_pair(16'd7, 16'd7);
   endtask

   task automatic test_known_pairs();
      send_pair(16'd220, 16'd284);
      send_pair(16'd284, 16'd220);
      send_pair(16'd1184, 16'd1210);
      send_pair(16'd1210, 16'd1184);
      send_pair(16'd220, 16'd285);
      send_pair(16'd221, 16'd284);
      send_pair(16'd2620, 16'd2924);
   endtask

   // Every bit high in both fields; the slowest word of the run.
   task automatic test_extremes();
      send_pair(16'hFFFF, 16'hFFFF);
   endtask

   // Mostly small numbers and known pairs with random order; some near misses and wider values.
   task automatic test_random_pairs(input int count);
      logic [NUM_WIDTH-1:0] a;
      logic [NUM_WIDTH-1:0] b;
      logic [NUM_WIDTH-1:0] t;
      int                   pick;
      int                   idx;
      repeat (count) begin
         pick = int'($urandom_range(0, 99));
         idx  = int'($urandom_range(0, 4));
         if (pick < 55) begin
            a = NUM_WIDTH'($urandom_range(0, 255));
            b = NUM_WIDTH'($urandom_range(0, 255));
         end else if (pick < 75) begin
            a = known_first[idx];
            b = known_second[idx];
         end else if (pick < 88) begin
            a = known_first[idx];
            b = $urandom_range(0, 1) ? known_second[idx] + 1'b1 : known_second[idx] - 1'b1;
         end else if (pick < 95) begin
            a = NUM_WIDTH'($urandom_range(0, 255));
            b = NUM_WIDTH'($urandom_range(0, 2047));
         end else begin
            a = NUM_WIDTH'($urandom_range(0, 2047));
            b = NUM_WIDTH'($urandom_range(0, 2047));
         end
         if ($urandom_range(0, 1)) begin
            t = a;
            a = b;
            b = t;
         end
         send_pair(a, b);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_pct   = 19;
      rsp_stall_pct = 78;
      test_zero_and_one();
      test_self_pairs();
      test_known_pairs();
      test_extremes();
      test_random_pairs(28);

      req_gap_pct   = 78;
      rsp_stall_pct = 19;
      test_random_pairs(27);

      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_random_pairs(26);

      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // Watchdog for the slowest legal run; reports errors if the run has not finished.
   initial begin
      #400ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
